[hw/rtl/tslf_pkg.sv]
// Shared constants for the text stream line formatter: characters, register map, defaults.
package tslf_pkg;

  localparam int unsigned NUMBER_DIGITS_DEF = 6;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SQUEEZE_BLANK    = 3'd1,
    REG_SHOW_ENDS        = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4
  } reg_idx_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CTRL_END  = 8'h20;  // first byte past the C0 controls
  localparam logic [7:0] CH_HIGH_LO   = 8'h80;
  localparam logic [7:0] CH_HIGH_END  = 8'hA0;  // first byte that passes raw
  localparam logic [7:0] CARET_OFFSET = 8'h40;

endpackage

[hw/rtl/text_stream_line_formatter.sv]
// Top level of the text stream line formatter: config registers, byte decode and beat sequencer.
//
// Formats a byte stream the way cat does: optional right-aligned line numbers
// (NUMBER_DIGITS places, space padded, then a tab, saturating at all nines),
// squeezing of blank-line runs, '$' before each newline, tabs as ^I, and
// control bytes as ^X, ^? or M-^X. Each accepted input byte yields from zero
// up to NUMBER_DIGITS+5 output beats; the final beat of a byte carries
// last_of_run. A byte that expands to one beat streams at one byte per clock;
// while char_ready is high; a byte of several beats holds the output beat
// sequencer until its last beat is taken. Input is taken into a one-entry
// holding register while the previous byte is still being emitted, so the
// input side stalls only when both the holding register and the sequencer
// are busy. A squeezed newline is accepted and yields no beat. Line counters
// advance at input acceptance; file_start clears them first. Configuration
// sits on an APB-style port (pready tied high, registers at byte addresses
// 0,4,...,16) and must be written only while idle; the block does not check.
module text_stream_line_formatter
  import tslf_pkg::*;
#(
  parameter int unsigned NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input byte channel
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [7:0]        data_byte,
  input  logic              file_start,
  // output character channel
  output logic              char_valid,
  input  logic              char_ready,
  output logic [7:0]        out_byte,
  output logic              last_of_run
);

  localparam int unsigned IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(NUMBER_DIGITS + 2);
  localparam logic [CNT_W-1:0] NUM_BEATS = CNT_W'(NUMBER_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_TAB   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_DIG0  = CNT_W'(2);

  typedef logic [3:0] digit_t;

  // Expansion record: everything the sequencer needs to emit one byte's beats.
  typedef struct packed {
    logic                         num;
    logic [NUMBER_DIGITS-1:0][3:0] bcd;
    logic [NUMBER_DIGITS-1:0]     blank;
    logic                         dollar;
    logic [1:0]                   pfx;
    logic [7:0]                   ch;
  } rec_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] number_mode;
  logic       squeeze_blank;
  logic       show_ends;
  logic       show_tabs;
  logic       show_nonprinting;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode      <= 2'd0;
      squeeze_blank    <= 1'b0;
      show_ends        <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUMBER_MODE:      number_mode      <= pwdata[1:0];
        REG_SQUEEZE_BLANK:    squeeze_blank    <= pwdata[0];
        REG_SHOW_ENDS:        show_ends        <= pwdata[0];
        REG_SHOW_TABS:        show_tabs        <= pwdata[0];
        REG_SHOW_NONPRINTING: show_nonprinting <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_NUMBER_MODE:      prdata[1:0] = number_mode;
      REG_SQUEEZE_BLANK:    prdata[0]   = squeeze_blank;
      REG_SHOW_ENDS:        prdata[0]   = show_ends;
      REG_SHOW_TABS:        prdata[0]   = show_tabs;
      REG_SHOW_NONPRINTING: prdata[0]   = show_nonprinting;
      default:              prdata      = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Line state: counter, start-of-line flag, newline run length
  // ---------------------------------------------------------------------------
  logic [NUMBER_DIGITS-1:0][3:0] line_bcd, line_bcd_next;
  logic                          line_pending, line_pending_next;
  logic [1:0]                    nl_run, nl_run_next;

  logic accept;
  logic drop;
  rec_t new_rec;

  always_comb begin
    logic [NUMBER_DIGITS-1:0][3:0] bcd_cur;
    logic [NUMBER_DIGITS-1:0][3:0] bcd_inc;
    logic                          pend_cur;
    logic [1:0]                    run_cur;
    logic                          is_nl;
    logic                          is_tab;
    logic                          all_nines;
    logic                          carry;
    logic                          lead;
    logic                          do_num;
    logic [7:0]                    ch;

    is_nl  = (data_byte == CH_NL);
    is_tab = (data_byte == CH_TAB);

    // file start clears the counters before the byte is handled
    bcd_cur  = file_start ? '0 : line_bcd;
    pend_cur = file_start ? 1'b1 : line_pending;
    run_cur  = file_start ? 2'd0 : nl_run;

    // squeeze: saturating newline run, drop from the third in a row on
    nl_run_next = run_cur;
    drop        = 1'b0;
    if (squeeze_blank) begin
      if (is_nl) begin
        nl_run_next = (run_cur == 2'd3) ? 2'd3 : run_cur + 2'd1;
      end else begin
        nl_run_next = 2'd0;
      end
      drop = (nl_run_next == 2'd3);
    end

    // saturating BCD increment
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      all_nines = all_nines & (bcd_cur[i] == digit_t'(9));
    end
    carry   = ~all_nines;
    bcd_inc = bcd_cur;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (bcd_cur[i] == digit_t'(9)) begin
          bcd_inc[i] = '0;
        end else begin
          bcd_inc[i] = bcd_cur[i] + digit_t'(1);
          carry      = 1'b0;
        end
      end
    end

    // numbering; mode three acts as non-blank only
    do_num            = (number_mode != 2'd0) && pend_cur && (!number_mode[1] || !is_nl);
    line_bcd_next     = do_num ? bcd_inc : bcd_cur;
    line_pending_next = pend_cur;
    if (number_mode != 2'd0) begin
      if (is_nl) begin
        line_pending_next = 1'b1;
      end else if (do_num) begin
        line_pending_next = 1'b0;
      end
    end
    // a dropped byte leaves numbering untouched
    if (drop) begin
      line_bcd_next     = bcd_cur;
      line_pending_next = pend_cur;
    end

    new_rec.num = do_num;
    new_rec.bcd = bcd_inc;
    lead        = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (bcd_inc[i] != '0 || i == 0) begin
        lead = 1'b0;
      end
      new_rec.blank[i] = lead;
    end

    new_rec.dollar = show_ends && is_nl;

    ch          = data_byte;
    new_rec.pfx = 2'd0;
    if (show_tabs && is_tab) begin
      new_rec.pfx = 2'd1;
      ch          = CH_I;
      is_tab      = 1'b0;
    end
    if (show_nonprinting && !is_nl && !is_tab) begin
      if (ch < CH_CTRL_END) begin
        new_rec.pfx = 2'd1;
        ch          = ch + CARET_OFFSET;
      end else if (ch == CH_DEL) begin
        new_rec.pfx = 2'd1;
        ch          = CH_QMARK;
      end else if (ch >= CH_HIGH_LO && ch < CH_HIGH_END) begin
        new_rec.pfx = 2'd3;
        ch          = ch - CARET_OFFSET;
      end
    end
    new_rec.ch = ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bcd     <= '0;
      line_pending <= 1'b1;
      nl_run       <= 2'd0;
    end else if (accept) begin
      line_bcd     <= line_bcd_next;
      line_pending <= line_pending_next;
      nl_run       <= nl_run_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Holding register and beat sequencer
  // ---------------------------------------------------------------------------
  logic             hold_valid;
  rec_t             hold;
  logic             emit_valid;
  logic [CNT_W-1:0] emit_cnt;
  logic             emit_dollar;
  logic [1:0]       emit_pfx;
  logic [7:0]       emit_ch;
  digit_t           emit_bcd [NUMBER_DIGITS];
  logic [NUMBER_DIGITS-1:0] emit_blank;

  logic             emit_last;
  logic             emit_free;
  logic             move;
  logic             beat;

  assign emit_last  = (emit_cnt == '0) && !emit_dollar && (emit_pfx == 2'd0);
  assign beat       = emit_valid && char_ready;
  assign emit_free  = !emit_valid || (char_ready && emit_last);
  assign move       = hold_valid && emit_free;
  assign byte_ready = !hold_valid || emit_free;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept && !drop) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      hold <= new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_valid  <= 1'b0;
      emit_cnt    <= '0;
      emit_dollar <= 1'b0;
      emit_pfx    <= 2'd0;
    end else if (move) begin
      emit_valid  <= 1'b1;
      emit_cnt    <= hold.num ? NUM_BEATS : '0;
      emit_dollar <= hold.dollar;
      emit_pfx    <= hold.pfx;
    end else if (beat) begin
      // retire the current beat: number first, then '$', then prefix, then char
      if (emit_last) begin
        emit_valid <= 1'b0;
      end else if (emit_cnt != '0) begin
        emit_cnt <= emit_cnt - CNT_W'(1);
      end else if (emit_dollar) begin
        emit_dollar <= 1'b0;
      end else begin
        emit_pfx <= emit_pfx - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      emit_ch    <= hold.ch;
      emit_blank <= hold.blank;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        emit_bcd[i] <= hold.bcd[i];
      end
    end
  end

  // Output character selection
  logic [CNT_W-1:0] dig_pos;
  logic [IDX_W-1:0] dig_idx;

  assign dig_pos = emit_cnt - CNT_DIG0;
  assign dig_idx = dig_pos[IDX_W-1:0];

  always_comb begin
    if (emit_cnt == CNT_TAB) begin
      out_byte = CH_TAB;
    end else if (emit_cnt != '0) begin
      out_byte = emit_blank[dig_idx] ? CH_SPACE : (CH_ZERO | {4'd0, emit_bcd[dig_idx]});
    end else if (emit_dollar) begin
      out_byte = CH_DOLLAR;
    end else if (emit_pfx == 2'd3) begin
      out_byte = CH_M;
    end else if (emit_pfx == 2'd2) begin
      out_byte = CH_DASH;
    end else if (emit_pfx == 2'd1) begin
      out_byte = CH_CARET;
    end else begin
      out_byte = emit_ch;
    end
  end

  assign char_valid  = emit_valid;
  assign last_of_run = emit_last;

endmodule

[hw/rtl/tslf_checker.sv]
// Port-level checks for the text stream line formatter, bound to the top level.
module tslf_checker
  import tslf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // hold a stalled beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output beat changed while stalled");

  // output side is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !char_valid)
    else $error("output valid after reset");

  // a newline is only ever the byte itself, so it closes its run
  a_nl_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && out_byte == CH_NL |-> last_of_run)
    else $error("newline beat not last of run");

  // an M prefix beat is followed by its dash
  a_meta_dash: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready && out_byte == CH_M && !last_of_run
      |=> char_valid && out_byte == CH_DASH)
    else $error("meta prefix not followed by dash");

endmodule

bind text_stream_line_formatter tslf_checker u_tslf_checker (
  .clk         (clk),
  .rst         (rst),
  .char_valid  (char_valid),
  .char_ready  (char_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
